// ===== sv/lhr_pkg.sv =====
package lhr_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int LINE_CHARS_DEF = 64;
   localparam int PREFIX_CAP     = 64;
   localparam int PFX_AW         = 6;
   localparam int CNT_W          = 7;
   localparam int IDX_W          = 4;
   localparam int SIZE_W         = 7;
   localparam int CHAR_W         = 8;
   localparam int MODE_W         = 3;
   localparam int READ_MAX       = 64;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 3'd0,
      MODE_PREFIX = 3'd1,
      MODE_PREV   = 3'd2,
      MODE_NEXT   = 3'd3,
      MODE_READ   = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_END,
      ST_COMMIT,
      ST_COMMIT_END,
      ST_REDUCE,
      ST_MOVED,
      ST_MATCH_RD,
      ST_MATCH_CMP,
      ST_ADVANCE,
      ST_READ_RD,
      ST_READ_CHK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic add_char;
      logic stg_reset;
      logic set_prefix;
      logic clear;
      logic step_init;
      logic reduce;
      logic take_t;
      logic advance;
      logic cnt_clr;
      logic cnt_inc;
      logic match_rd;
      logic read_rd;
      logic commit_rd;
      logic commit_end;
      logic set_res;
      logic res_from_s;
      logic emit;
      logic emit_char;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     last;
      logic     nonblank;
      logic     init_stop;
      logic     is_back;
      logic     t_ge;
      logic     s_eq_newest;
      logic     s_eq_oldest;
      logic     cnt_eq_pfx;
      logic     cmp_eq;
      logic     commit_last;
      logic     read_end;
      logic     rd_zero;
      logic     rsp_free;
   } status_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

endpackage

// ===== sv/line_history_ring_prefix_search.sv =====
// channel  handshake             payload
// req      req_valid/req_ready   req_mode, req_char_in, req_last, req_index_in, req_read_size
// rsp      rsp_valid/rsp_ready   rsp_index_out, rsp_char_out, rsp_last_out, rsp_is_empty,
//                                rsp_at_end, rsp_start_index
//
// One item at a time: a character or prefix item is captured, dispatched and answered;
// a committed line also copies LINE_CHARS chars from the staging buffer into the ring.
// A step walks the slots, comparing the prefix one char at a time over the line store
// read port; a read gives its chars one at a time, each waiting for the output register.
// Reset clears pointers and per-row valid bits at once, so no clearing pass is run.
// A stalled result holds in the output register; the next item is taken meanwhile.
module line_history_ring_prefix_search import lhr_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [CHAR_W-1:0]   req_char_in,
   input  logic                req_last,
   input  logic [IDX_W-1:0]    req_index_in,
   input  logic [SIZE_W-1:0]   req_read_size,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IDX_W-1:0]    rsp_index_out,
   output logic [CHAR_W-1:0]   rsp_char_out,
   output logic                rsp_last_out,
   output logic                rsp_is_empty,
   output logic                rsp_at_end,
   output logic [IDX_W-1:0]    rsp_start_index
);

   cmd_type    cmd;
   status_type st;

   lhr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   lhr_datapath #(
      .ENTRIES    (ENTRIES),
      .LINE_CHARS (LINE_CHARS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_mode        (req_mode),
      .req_char_in     (req_char_in),
      .req_last        (req_last),
      .req_index_in    (req_index_in),
      .req_read_size   (req_read_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_index_out   (rsp_index_out),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_out    (rsp_last_out),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_at_end      (rsp_at_end),
      .rsp_start_index (rsp_start_index)
   );

endmodule

// ===== sv/lhr_ctrl.sv =====
module lhr_ctrl import lhr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (st.mode)
               MODE_ADD: begin
                  cmd.add_char = 1'b1;
                  state_in     = st.last ? ST_ADD_END : ST_RESULT;
               end
               MODE_PREFIX: begin
                  cmd.set_prefix = 1'b1;
                  state_in       = ST_RESULT;
               end
               MODE_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_RESULT;
               end
               MODE_PREV, MODE_NEXT: begin
                  if (st.init_stop) begin
                     cmd.set_res = 1'b1;
                     state_in    = ST_RESULT;
                  end else begin
                     cmd.step_init = 1'b1;
                     state_in      = ST_REDUCE;
                  end
               end
               MODE_READ: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_READ_RD;
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_ADD_END: begin
            if (st.nonblank) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_COMMIT;
            end else begin
               cmd.stg_reset = 1'b1;
               state_in      = ST_RESULT;
            end
         end
         ST_COMMIT: begin
            cmd.commit_rd = 1'b1;
            if (st.commit_last) state_in = ST_COMMIT_END;
         end
         ST_COMMIT_END: begin
            cmd.commit_end = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_REDUCE: begin
            if (st.t_ge) begin
               cmd.reduce = 1'b1;
            end else begin
               cmd.take_t = 1'b1;
               state_in   = ST_MOVED;
            end
         end
         ST_MOVED: begin
            // forward step onto the newest slot ends the walk there
            if (!st.is_back && st.s_eq_newest) begin
               cmd.set_res    = 1'b1;
               cmd.res_from_s = 1'b1;
               state_in       = ST_RESULT;
            end else begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_MATCH_RD;
            end
         end
         ST_MATCH_RD: begin
            if (st.cnt_eq_pfx) begin
               cmd.set_res    = 1'b1;
               cmd.res_from_s = 1'b1;
               state_in       = ST_RESULT;
            end else begin
               cmd.match_rd = 1'b1;
               state_in     = ST_MATCH_CMP;
            end
         end
         ST_MATCH_CMP: begin
            if (st.cmp_eq) begin
               cmd.cnt_inc = 1'b1;
               state_in    = ST_MATCH_RD;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            if (st.is_back ? st.s_eq_oldest : st.s_eq_newest) begin
               cmd.set_res = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_MOVED;
            end
         end
         ST_READ_RD: begin
            if (st.read_end) begin
               state_in = ST_RESULT;
            end else begin
               cmd.read_rd = 1'b1;
               state_in    = ST_READ_CHK;
            end
         end
         ST_READ_CHK: begin
            if (st.rd_zero) begin
               state_in = ST_RESULT;
            end else if (st.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_char = 1'b1;
               cmd.cnt_inc   = 1'b1;
               state_in      = ST_READ_RD;
            end
         end
         ST_RESULT: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/lhr_datapath.sv =====
module lhr_datapath import lhr_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          st,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [CHAR_W-1:0]   req_char_in,
   input  logic                req_last,
   input  logic [IDX_W-1:0]    req_index_in,
   input  logic [SIZE_W-1:0]   req_read_size,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IDX_W-1:0]    rsp_index_out,
   output logic [CHAR_W-1:0]   rsp_char_out,
   output logic                rsp_last_out,
   output logic                rsp_is_empty,
   output logic                rsp_at_end,
   output logic [IDX_W-1:0]    rsp_start_index
);

   localparam int SW = $clog2(ENTRIES);
   localparam int LW = $clog2(LINE_CHARS);
   localparam int IW = (SW > IDX_W) ? SW : IDX_W;
   localparam int TW = IW + 1;

   logic [CHAR_W-1:0] line_mem  [0:(2**SW)*(2**LW)-1];
   logic [CHAR_W-1:0] stage_mem [0:(2**LW)-1];
   logic [CHAR_W-1:0] pfx_mem   [0:PREFIX_CAP-1];

   mode_type            cur_mode_ff;
   logic [CHAR_W-1:0]   cur_char_ff;
   logic                cur_last_ff;
   logic [IDX_W-1:0]    cur_idx_ff;
   logic [SIZE_W-1:0]   cur_size_ff;

   logic [SW-1:0]       newest_ff, oldest_ff;
   logic [ENTRIES-1:0]  row_valid_ff;
   logic [LW-1:0]       stg_count_ff;
   logic                stg_nonblank_ff, stg_ended_ff;
   logic [CNT_W-1:0]    pfx_count_ff;
   logic                pfx_restart_ff;

   logic [TW-1:0]       t_ff;
   logic [SW-1:0]       s_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [IW-1:0]       res_idx_ff;

   logic [CHAR_W-1:0]   line_rd_ff, stg_rd_ff, pfx_rd_ff;
   logic                line_rv_ff;
   logic                cmt_wr_ff;
   logic [LW-1:0]       cmt_col_ff;

   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_start_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic                rsp_last_ff, rsp_empty_ff, rsp_at_end_ff;

   logic [IW-1:0]       idx_ext, newest_ext, emit_idx;
   logic [SW-1:0]       prev_s, next_s, next_newest, next_oldest, rd_slot;
   logic                is_back, is_step, slot_ok, rsp_free;
   logic [SIZE_W-1:0]   size_clamp;
   logic [CNT_W-1:0]    read_lim, pfx_eff;

   assign idx_ext     = IW'(cur_idx_ff);
   assign newest_ext  = IW'(newest_ff);
   assign is_back     = (cur_mode_ff == MODE_PREV);
   assign is_step     = (cur_mode_ff == MODE_PREV) || (cur_mode_ff == MODE_NEXT);
   assign prev_s      = (s_ff == '0) ? SW'(ENTRIES - 1) : s_ff - 1'b1;
   assign next_s      = (s_ff == SW'(ENTRIES - 1)) ? '0 : s_ff + 1'b1;
   assign next_newest = (newest_ff == SW'(ENTRIES - 1)) ? '0 : newest_ff + 1'b1;
   assign next_oldest = (oldest_ff == SW'(ENTRIES - 1)) ? '0 : oldest_ff + 1'b1;
   assign slot_ok     = TW'(idx_ext) < TW'(ENTRIES);
   assign rd_slot     = idx_ext[SW-1:0];
   assign size_clamp  = (cur_size_ff == '0) ? SIZE_W'(1) :
                        (cur_size_ff > SIZE_W'(READ_MAX)) ? SIZE_W'(READ_MAX) : cur_size_ff;
   assign read_lim    = CNT_W'(size_clamp - 1'b1);
   assign pfx_eff     = pfx_restart_ff ? '0 : pfx_count_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign emit_idx    = (is_step && !cmd.emit_char) ? res_idx_ff : newest_ext;

   always_comb begin
      st             = '0;
      st.mode        = cur_mode_ff;
      st.last        = cur_last_ff;
      st.nonblank    = stg_nonblank_ff;
      st.init_stop   = is_back ? (idx_ext == IW'(oldest_ff)) : (idx_ext == newest_ext);
      st.is_back     = is_back;
      st.t_ge        = t_ff >= TW'(ENTRIES);
      st.s_eq_newest = (s_ff == newest_ff);
      st.s_eq_oldest = (s_ff == oldest_ff);
      st.cnt_eq_pfx  = (cnt_ff == pfx_count_ff);
      // past the end of a line the line reads as zero
      st.cmp_eq      = (((line_rv_ff && cnt_ff < CNT_W'(LINE_CHARS)) ? line_rd_ff : '0)
                        == pfx_rd_ff);
      st.commit_last = (cnt_ff == CNT_W'(LINE_CHARS - 1));
      st.read_end    = !slot_ok || (cnt_ff == read_lim) || (cnt_ff == CNT_W'(LINE_CHARS));
      st.rd_zero     = !line_rv_ff || (line_rd_ff == '0);
      st.rsp_free    = rsp_free;
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_mode_ff <= mode_type'(req_mode);
         cur_char_ff <= req_char_in;
         cur_last_ff <= req_last;
         cur_idx_ff  <= req_index_in;
         cur_size_ff <= req_read_size;
      end
   end

   // ring pointers, row valid bits, staging and prefix control
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff       <= '0;
         oldest_ff       <= '0;
         row_valid_ff    <= '0;
         stg_count_ff    <= '0;
         stg_nonblank_ff <= 1'b0;
         stg_ended_ff    <= 1'b0;
         pfx_count_ff    <= '0;
         pfx_restart_ff  <= 1'b1;
      end else begin
         if (cmd.add_char && !stg_ended_ff) begin
            if (cur_char_ff == '0) begin
               stg_ended_ff <= 1'b1;
            end else begin
               if (!is_space(cur_char_ff)) stg_nonblank_ff <= 1'b1;
               if (stg_count_ff < LW'(LINE_CHARS - 1)) stg_count_ff <= stg_count_ff + 1'b1;
            end
         end
         if (cmd.stg_reset || cmd.commit_end) begin
            stg_count_ff    <= '0;
            stg_nonblank_ff <= 1'b0;
            stg_ended_ff    <= 1'b0;
         end
         if (cmd.set_prefix) begin
            if (cur_char_ff != '0 && pfx_eff < CNT_W'(PREFIX_CAP)) begin
               pfx_count_ff <= pfx_eff + 1'b1;
            end else begin
               pfx_count_ff <= pfx_eff;
            end
            pfx_restart_ff <= cur_last_ff;
         end
         if (cmd.commit_end) begin
            newest_ff               <= next_newest;
            row_valid_ff[newest_ff] <= 1'b1;
            if (next_newest == oldest_ff) oldest_ff <= next_oldest;
         end
         if (cmd.clear) begin
            newest_ff    <= '0;
            oldest_ff    <= '0;
            row_valid_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_char && !stg_ended_ff && cur_char_ff != '0 &&
          stg_count_ff < LW'(LINE_CHARS - 1)) begin
         stage_mem[stg_count_ff] <= cur_char_ff;
      end
      if (cmd.commit_rd) begin
         stg_rd_ff <= stage_mem[cnt_ff[LW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_prefix && cur_char_ff != '0 && pfx_eff < CNT_W'(PREFIX_CAP)) begin
         pfx_mem[pfx_eff[PFX_AW-1:0]] <= cur_char_ff;
      end
      if (cmd.match_rd) begin
         pfx_rd_ff <= pfx_mem[cnt_ff[PFX_AW-1:0]];
      end
   end

   // line store: one write, one read per cycle
   always_ff @(posedge clock) begin
      if (cmt_wr_ff) begin
         line_mem[{newest_ff, cmt_col_ff}] <= (cmt_col_ff < stg_count_ff) ? stg_rd_ff : '0;
      end
      if (cmd.match_rd) begin
         line_rd_ff <= line_mem[{s_ff, cnt_ff[LW-1:0]}];
         line_rv_ff <= row_valid_ff[s_ff];
      end else if (cmd.read_rd) begin
         line_rd_ff <= line_mem[{rd_slot, cnt_ff[LW-1:0]}];
         line_rv_ff <= row_valid_ff[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmt_wr_ff <= 1'b0;
      end else begin
         cmt_wr_ff <= cmd.commit_rd;
      end
      if (cmd.commit_rd) cmt_col_ff <= cnt_ff[LW-1:0];
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc || cmd.commit_rd) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.step_init) begin
         t_ff <= is_back ? TW'(idx_ext) + TW'(ENTRIES - 1) : TW'(idx_ext) + TW'(1);
      end else if (cmd.reduce) begin
         t_ff <= t_ff - TW'(ENTRIES);
      end
      if (cmd.take_t) begin
         s_ff <= t_ff[SW-1:0];
      end else if (cmd.advance) begin
         s_ff <= is_back ? prev_s : next_s;
      end
      if (cmd.set_res) begin
         res_idx_ff <= cmd.res_from_s ? IW'(s_ff) : idx_ext;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_index_ff  <= emit_idx[IDX_W-1:0];
         rsp_char_ff   <= cmd.emit_char ? line_rd_ff : '0;
         rsp_last_ff   <= !cmd.emit_char;
         rsp_empty_ff  <= (newest_ff == oldest_ff);
         rsp_at_end_ff <= (emit_idx == newest_ext);
         rsp_start_ff  <= newest_ext[IDX_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_out   = rsp_index_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_last_out    = rsp_last_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_at_end      = rsp_at_end_ff;
   assign rsp_start_index = rsp_start_ff;

endmodule

// ===== tb/line_history_ring_prefix_search_test.sv =====
module line_history_ring_prefix_search_test;
   import lhr_pkg::*;

   localparam int NSLOT = 16;
   localparam int LLEN  = 64;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [IDX_W-1:0]  index_out;
      logic [CHAR_W-1:0] char_out;
      logic              last_out;
      logic              is_empty;
      logic              at_end;
      logic [IDX_W-1:0]  start_index;
   } hist_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [CHAR_W-1:0]   req_char_in;
   logic                req_last;
   logic [IDX_W-1:0]    req_index_in;
   logic [SIZE_W-1:0]   req_read_size;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [IDX_W-1:0]    rsp_index_out;
   logic [CHAR_W-1:0]   rsp_char_out;
   logic                rsp_last_out;
   logic                rsp_is_empty;
   logic                rsp_at_end;
   logic [IDX_W-1:0]    rsp_start_index;

   // shadow of the history ring
   logic [7:0]  ring_text [NSLOT][LLEN];
   logic [3:0]  head_slot;
   logic [3:0]  tail_slot;
   logic [7:0]  edit_buf [64];
   int          edit_len;
   bit          edit_nonblank;
   bit          edit_done;
   logic [7:0]  pfx_buf [64];
   int          pfx_len;
   bit          pfx_fresh;

   hist_rsp_type expected_rsps [$];
   int          errors;
   int          items_sent;
   int          rsps_seen;
   int          stall_hold;
   bit          no_idle;

   line_history_ring_prefix_search dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("[line_history_ring_prefix_search] ERROR");
      $finish;
   end

   function automatic bit is_blank_char(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit slot_has_prefix(logic [3:0] s);
      for (int i = 0; i < pfx_len; i++)
         if (ring_text[s][i] != pfx_buf[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [3:0] walk_back(logic [3:0] idx);
      logic [3:0] s;
      s = idx;
      if (pfx_len == 0) return (idx != tail_slot) ? idx - 4'd1 : idx;
      while (s != tail_slot) begin
         s = s - 4'd1;
         if (slot_has_prefix(s)) return s;
      end
      return idx;
   endfunction

   function automatic logic [3:0] walk_fwd(logic [3:0] idx);
      logic [3:0] s;
      s = idx;
      if (pfx_len == 0) return (idx != head_slot) ? idx + 4'd1 : idx;
      while (s != head_slot) begin
         s = s + 4'd1;
         if (s == head_slot) return s;
         if (slot_has_prefix(s)) return s;
      end
      return idx;
   endfunction

   function automatic void push_rsp(logic [3:0] idx, logic [7:0] c, logic fin);
      hist_rsp_type r;
      r.index_out   = idx;
      r.char_out    = c;
      r.last_out    = fin;
      r.is_empty    = head_slot == tail_slot;
      r.at_end      = idx == head_slot;
      r.start_index = head_slot;
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_history(logic [2:0] mode, logic [7:0] c, logic fin,
                                           logic [3:0] idx, logic [6:0] size);
      int lim;
      case (mode)
         MODE_ADD: begin
            if (!edit_done) begin
               if (c == 0) edit_done = 1'b1;
               else begin
                  if (!is_blank_char(c)) edit_nonblank = 1'b1;
                  if (edit_len < LLEN - 1) begin
                     edit_buf[edit_len] = c;
                     edit_len++;
                  end
               end
            end
            if (fin) begin
               if (edit_nonblank) begin
                  for (int i = 0; i < LLEN; i++)
                     ring_text[head_slot][i] = (i < edit_len) ? edit_buf[i] : 8'd0;
                  head_slot = head_slot + 4'd1;
                  if (head_slot == tail_slot) tail_slot = tail_slot + 4'd1;
               end
               edit_len = 0;
               edit_nonblank = 1'b0;
               edit_done = 1'b0;
            end
            push_rsp(head_slot, 8'd0, 1'b1);
         end
         MODE_PREFIX: begin
            if (pfx_fresh) begin
               pfx_len = 0;
               pfx_fresh = 1'b0;
            end
            if (c != 0 && pfx_len < 64) begin
               pfx_buf[pfx_len] = c;
               pfx_len++;
            end
            if (fin) pfx_fresh = 1'b1;
            push_rsp(head_slot, 8'd0, 1'b1);
         end
         MODE_PREV: push_rsp(walk_back(idx), 8'd0, 1'b1);
         MODE_NEXT: push_rsp(walk_fwd(idx), 8'd0, 1'b1);
         MODE_READ: begin
            lim = (size == 0) ? 1 : (size > 64 ? 64 : size);
            lim = lim - 1;
            for (int i = 0; i < lim; i++) begin
               if (ring_text[idx][i] == 0) break;
               push_rsp(head_slot, ring_text[idx][i], 1'b0);
            end
            push_rsp(head_slot, 8'd0, 1'b1);
         end
         MODE_CLEAR: begin
            foreach (ring_text[s, i]) ring_text[s][i] = 8'd0;
            head_slot = '0;
            tail_slot = '0;
            push_rsp(head_slot, 8'd0, 1'b1);
         end
         default: push_rsp(head_slot, 8'd0, 1'b1);
      endcase
   endfunction

   // valid stays high into the next item when there is no gap
   task automatic send_item(logic [2:0] mode, logic [7:0] c, logic fin,
                            logic [3:0] idx, logic [6:0] size);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_char_in   <= c;
      req_last      <= fin;
      req_index_in  <= idx;
      req_read_size <= size;
      do @(posedge clock); while (!req_ready);
      predict_history(mode, c, fin, idx, size);
      items_sent++;
   endtask

   task automatic send_line(string s, bit with_nul);
      for (int i = 0; i < s.len(); i++)
         send_item(MODE_ADD, s[i], (i == s.len() - 1) && !with_nul, 4'($urandom), 7'($urandom));
      if (with_nul || s.len() == 0) send_item(MODE_ADD, 8'd0, 1'b1, 4'd0, 7'd0);
   endtask

   task automatic send_prefix(string s);
      if (s.len() == 0) send_item(MODE_PREFIX, 8'd0, 1'b1, 4'd0, 7'd1);
      for (int i = 0; i < s.len(); i++)
         send_item(MODE_PREFIX, s[i], i == s.len() - 1, 4'($urandom), 7'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // receiver: random stall per result, plus a long hold-off on request
   initial begin
      hist_rsp_type e;
      hist_rsp_type a;
      int w;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (stall_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_hold) @(posedge clock);
            stall_hold = 0;
         end
         w = no_idle ? 0 : $urandom_range(0, 18);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         a = {rsp_index_out, rsp_char_out, rsp_last_out, rsp_is_empty, rsp_at_end,
              rsp_start_index};
         rsps_seen++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, a);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (a.index_out != e.index_out)
               $display("%0t: index_out exp %0d got %0d", $time, e.index_out, a.index_out);
            if (a.char_out != e.char_out)
               $display("%0t: char_out exp %0d got %0d", $time, e.char_out, a.char_out);
            if (a.last_out != e.last_out)
               $display("%0t: last_out exp %0d got %0d", $time, e.last_out, a.last_out);
            if (a.is_empty != e.is_empty)
               $display("%0t: is_empty exp %0d got %0d", $time, e.is_empty, a.is_empty);
            if (a.at_end != e.at_end)
               $display("%0t: at_end exp %0d got %0d", $time, e.at_end, a.at_end);
            if (a.start_index != e.start_index)
               $display("%0t: start_index exp %0d got %0d", $time, e.start_index,
                        a.start_index);
            if (a != e) errors++;
         end
      end
   end

   task automatic test_directed();
      send_item(MODE_READ, 8'd0, 1'b1, 4'd0, 7'd64);
      send_item(MODE_PREV, 8'd0, 1'b1, 4'd0, 7'd1);
      send_line("ab", 1'b0);
      send_line(" \t", 1'b0);            // whitespace only: dropped
      send_item(MODE_ADD, 8'd0, 1'b1, 4'd0, 7'd0);   // empty line
      send_line("q", 1'b1);
      send_item(MODE_ADD, 8'hff, 1'b1, 4'd0, 7'd0);
      send_item(MODE_READ, 8'd0, 1'b1, 4'd0, 7'd0);  // size zero
      send_item(MODE_READ, 8'd0, 1'b1, 4'd15, 7'd127);
      send_prefix("a");
      send_item(MODE_PREV, 8'd0, 1'b1, 4'd3, 7'd1);
      send_item(MODE_NEXT, 8'd0, 1'b1, 4'd0, 7'd1);
      send_item(MODE_SPARE_LO, 8'd0, 1'b0, 4'd0, 7'd1);
      send_item(MODE_SPARE_HI, 8'd0, 1'b1, 4'd0, 7'd1);
      send_item(MODE_CLEAR, 8'd0, 1'b1, 4'd0, 7'd1);
      wait_drained();
   endtask

   task automatic test_long_line();
      // more than a line holds, trailing chars beyond what the line keeps, a long prefix
      for (int i = 0; i < 66; i++)
         send_item(MODE_ADD, (i < 63) ? 8'(65 + i % 26) : 8'h7e, i == 65, 4'd0, 7'd0);
      for (int i = 0; i < 66; i++)
         send_item(MODE_PREFIX, 8'(65 + i % 26), i == 65, 4'd0, 7'd0);
      send_item(MODE_PREV, 8'd0, 1'b1, 4'd1, 7'd1);
      send_item(MODE_READ, 8'd0, 1'b1, 4'd0, 7'd64);
      send_item(MODE_READ, 8'd0, 1'b1, 4'd0, 7'd65);
      send_prefix("");
      wait_drained();
   endtask

   task automatic test_backpressure();
      stall_hold = 300;
      for (int i = 0; i < 20; i++) send_item(MODE_READ, 8'd0, 1'b1, 4'($urandom), 7'd4);
      wait_drained();
   endtask

   task automatic test_random(int n);
      int r;
      int len;
      logic [7:0] c;
      string pfx_pool [4];
      pfx_pool = '{"a", "ab", "b", "ba"};
      while (items_sent < n) begin
         no_idle = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            len = $urandom_range(0, 5);
            for (int i = 0; i <= len; i++) begin
               c = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                   (($urandom_range(0, 5) == 0) ? 8'd32 : 8'(97 + $urandom_range(0, 2)));
               send_item(MODE_ADD, c, i == len, 4'($urandom), 7'($urandom));
            end
         end else if (r < 48) begin
            send_prefix(($urandom_range(0, 4) == 0) ? "" : pfx_pool[$urandom_range(0, 3)]);
         end else if (r < 75) begin
            send_item($urandom_range(0, 1) ? MODE_PREV : MODE_NEXT, 8'($urandom),
                      1'($urandom), 4'($urandom), 7'($urandom));
         end else if (r < 95) begin
            send_item(MODE_READ, 8'($urandom), 1'($urandom), 4'($urandom),
                      ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8)));
         end else if (r < 97) begin
            send_item(MODE_CLEAR, 8'($urandom), 1'($urandom), 4'($urandom), 7'($urandom));
         end else begin
            send_item($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI, 8'($urandom),
                      1'($urandom), 4'($urandom), 7'($urandom));
         end
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   initial begin
      foreach (ring_text[s, i]) ring_text[s][i] = 8'd0;
      head_slot = '0; tail_slot = '0;
      edit_len = 0; edit_nonblank = 0; edit_done = 0;
      pfx_len = 0; pfx_fresh = 1;
      errors = 0; items_sent = 0; rsps_seen = 0; stall_hold = 0; no_idle = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_mode = '0; req_char_in = '0; req_last = 1'b0;
      req_index_in = '0; req_read_size = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_line();
      test_backpressure();
      test_random(500);
      repeat (200) @(posedge clock);
      $display("Sent %0d items (adds, prefixes, steps, reads, clears, unused modes),",
               items_sent);
      $display("checked %0d results with %0d mismatching.", rsps_seen, errors);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("[line_history_ring_prefix_search] OK");
      else
         $display("[line_history_ring_prefix_search] ERROR");
      $finish;
   end

endmodule
